/* rtl/prd_pkg.sv */
// ----------------------------------------------------------------------------
// prd_pkg: shared definitions for the phase residue detector
// Widths, register indexes, residue codes and the structs passed between the
// raster sequencer, the loop classifier and the top level.
// ----------------------------------------------------------------------------
package prd_pkg;

	// Sizing of the line store and of the phase fraction
	localparam int MAX_WIDTH  = 1024;
	localparam int PHASE_BITS = 16;

	// Fixed field widths of the channels and the register port
	localparam int PHASE_IN_W = 16;
	localparam int LW_W       = 11;
	localparam int FH_W       = 16;
	localparam int CFG_W      = 16;
	localparam int COL_OUT_W  = 10;
	localparam int ROW_W      = 16;
	localparam int CNT_W      = 26;

	// Derived widths
	localparam int ADDR_W  = $clog2(MAX_WIDTH);
	localparam int LIM_W   = ($clog2(MAX_WIDTH + 1) > LW_W) ? $clog2(MAX_WIDTH + 1) : LW_W;
	localparam int PIX_W   = PHASE_BITS + 1;
	localparam int DIFF_W  = PHASE_BITS + 1;
	localparam int SUM_W   = DIFF_W + 2;

	// Register reset values
	localparam logic [LW_W-1:0] LINE_WIDTH_RESET   = LW_W'(1024);
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = FH_W'(1024);

	typedef enum logic [0:0] {
		REG_LINE_WIDTH   = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		CODE_NONE = 2'd0,
		CODE_POS  = 2'd1,
		CODE_NEG  = 2'd2,
		CODE_SKIP = 2'd3
	} code_t;

	// Stored pixel: mask bit above the phase
	typedef struct packed {
		logic                  avoid;
		logic [PHASE_BITS-1:0] phase;
	} pixel_t;

	// Raster position of one request and what it completes
	typedef struct packed {
		logic [ADDR_W-1:0] column;
		logic [ROW_W-1:0]  row;
		logic              window;
		logic              last;
	} raster_t;

endpackage

/* rtl/prd_pixel_if.sv */
// ----------------------------------------------------------------------------
// prd_pixel_if: wrapped phase pixel channel
// Valid/ready channel carrying one phase sample and its mask bit.
// ----------------------------------------------------------------------------
interface prd_pixel_if;
	import prd_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [PHASE_IN_W-1:0] phase;
	logic                  avoid;

	modport source (output valid, phase, avoid, input ready);
	modport sink   (input valid, phase, avoid, output ready);

endinterface

/* rtl/prd_residue_if.sv */
// ----------------------------------------------------------------------------
// prd_residue_if: residue result channel
// Valid/ready channel carrying one classified 2x2 window.
// ----------------------------------------------------------------------------
interface prd_residue_if;
	import prd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [COL_OUT_W-1:0] column;
	logic [ROW_W-1:0]     row;
	code_t                code;
	logic [CNT_W-1:0]     residue_count;
	logic                 last;

	modport source (output valid, column, row, code, residue_count, last, input ready);
	modport sink   (input valid, column, row, code, residue_count, last, output ready);

endinterface

/* rtl/prd_ram.sv */
// ----------------------------------------------------------------------------
// prd_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module prd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read; data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/prd_raster.sv */
// ----------------------------------------------------------------------------
// prd_raster: register file and raster position sequencer
// Holds the frame geometry registers and the column and row counters, and
// flags whether each request completes a window and whether it ends a frame.
// ----------------------------------------------------------------------------
module prd_raster (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  prd_pkg::reg_index_t         cfg_index,
	input  logic [prd_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        advance,
	output prd_pkg::raster_t            pos
);
	import prd_pkg::*;

	logic [LW_W-1:0]   line_width_q;
	logic [FH_W-1:0]   frame_height_q;
	logic [ADDR_W-1:0] column_q;
	logic [ROW_W-1:0]  row_q;

	logic [LIM_W-1:0]  width_eff;
	logic [FH_W-1:0]   height_eff;
	logic [LIM_W-1:0]  col_inc;
	logic [ROW_W:0]    row_inc;
	logic              col_wrap;
	logic              row_wrap;

	// Take register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= LINE_WIDTH_RESET;
			frame_height_q <= FRAME_HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LINE_WIDTH:   line_width_q   <= cfg_data[LW_W-1:0];
				REG_FRAME_HEIGHT: frame_height_q <= cfg_data[FH_W-1:0];
			endcase
		end
	end

	// Clamp the geometry to its usable range
	always_comb begin
		width_eff = LIM_W'(line_width_q);
		priority if (width_eff < LIM_W'(2)) begin
			width_eff = LIM_W'(2);
		end else if (width_eff > LIM_W'(MAX_WIDTH)) begin
			width_eff = LIM_W'(MAX_WIDTH);
		end
		height_eff = frame_height_q;
		if (height_eff < FH_W'(2)) begin
			height_eff = FH_W'(2);
		end
	end

	// Work out wrap conditions of the counters
	assign col_inc  = LIM_W'(column_q) + LIM_W'(1);
	assign row_inc  = (ROW_W + 1)'(row_q) + (ROW_W + 1)'(1);
	assign col_wrap = col_inc >= width_eff;
	assign row_wrap = row_inc >= (ROW_W + 1)'(height_eff);

	// Describe the current request
	always_comb begin
		pos.column = column_q;
		pos.row    = row_q;
		pos.window = (column_q != '0) && (row_q != '0);
		pos.last   = col_wrap && row_wrap;
	end

	// Advance the raster position on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (advance) begin
			if (col_wrap) begin
				column_q <= '0;
				row_q    <= row_wrap ? '0 : row_inc[ROW_W-1:0];
			end else begin
				column_q <= col_inc[ADDR_W-1:0];
			end
		end
	end

endmodule

/* rtl/prd_classify.sv */
// ----------------------------------------------------------------------------
// prd_classify: 2x2 loop residue classifier
// Sums the four wrapped phase differences around a window and turns the
// whole-cycle result into a residue code; masked corners skip the window.
// ----------------------------------------------------------------------------
module prd_classify (
	input  prd_pkg::pixel_t upper_left,
	input  prd_pkg::pixel_t up,
	input  prd_pkg::pixel_t cur,
	input  prd_pkg::pixel_t left,
	output prd_pkg::code_t  code
);
	import prd_pkg::*;

	localparam logic signed [PHASE_BITS+1:0] FULL = {2'b01, {PHASE_BITS{1'b0}}};
	localparam logic signed [PHASE_BITS+1:0] HALF = {3'b001, {(PHASE_BITS-1){1'b0}}};

	// Difference of two phases folded into half a cycle either way
	function automatic logic signed [DIFF_W-1:0] wrap_diff(
		input logic [PHASE_BITS-1:0] a,
		input logic [PHASE_BITS-1:0] b
	);
		logic signed [PHASE_BITS+1:0] raw;
		logic signed [PHASE_BITS+1:0] folded;
		raw = $signed({2'b00, a}) - $signed({2'b00, b});
		if (raw > HALF) begin
			folded = raw - FULL;
		end else if (raw < -HALF) begin
			folded = raw + FULL;
		end else begin
			folded = raw;
		end
		return $signed(folded[DIFF_W-1:0]);
	endfunction

	logic signed [DIFF_W-1:0] d_top;
	logic signed [DIFF_W-1:0] d_right;
	logic signed [DIFF_W-1:0] d_bottom;
	logic signed [DIFF_W-1:0] d_left;
	logic signed [SUM_W-1:0]  loop_sum;
	logic                     masked;

	// Walk the loop clockwise from the top-left corner
	assign d_top    = wrap_diff(up.phase, upper_left.phase);
	assign d_right  = wrap_diff(cur.phase, up.phase);
	assign d_bottom = wrap_diff(left.phase, cur.phase);
	assign d_left   = wrap_diff(upper_left.phase, left.phase);

	assign loop_sum = SUM_W'(d_top) + SUM_W'(d_right) + SUM_W'(d_bottom) + SUM_W'(d_left);
	assign masked   = upper_left.avoid | up.avoid | cur.avoid | left.avoid;

	// Classify by sign of the loop sum
	always_comb begin
		priority if (masked) begin
			code = CODE_SKIP;
		end else if (loop_sum > SUM_W'(0)) begin
			code = CODE_POS;
		end else if (loop_sum < SUM_W'(0)) begin
			code = CODE_NEG;
		end else begin
			code = CODE_NONE;
		end
	end

endmodule

/* rtl/phase_residue_detector_top.sv */
// ----------------------------------------------------------------------------
// phase_residue_detector_top: streaming Goldstein phase residue detector
// Pixels in raster order in, one classified 2x2 window per completing pixel
// out.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock cycle while the output is
// not stalled. The line store read is registered together with the
// accepted pixel in stage one. As stage one advances, the loop sum
// and code go into the output register. The pipeline holds at most
// two pixels. A stalled result first holds stage one and then the input,
// so a stall on the output reaches the input after at most one more pixel.
// The previous row lives in a single MAX_WIDTH x (PHASE_BITS+1) RAM with one
// read port and one write port. Each pixel reads its column and writes itself
// back as it leaves the compare stage, so the RAM ports set the rate of one
// pixel a cycle. The line store is not cleared after reset: the first row of
// every frame fills it before any window reads it. Pixels in the first row or
// column give no result. The residue count saturates and returns to zero
// after the window marked last. Write line_width and frame_height only while
// no pixel is in flight. A change in mid-frame wraps the counters as soon as
// they reach the new limit.
// ----------------------------------------------------------------------------
module phase_residue_detector_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  prd_pkg::reg_index_t       cfg_index,
	input  logic [prd_pkg::CFG_W-1:0] cfg_data,
	prd_pixel_if.sink                 pixel_in,
	prd_residue_if.source             residue_out
);
	import prd_pkg::*;

	logic              in_fire;
	logic              out_free;
	logic              s1_adv;
	raster_t           pos;
	pixel_t            cur_in;

	logic              valid_s1;
	raster_t           pos_s1;
	pixel_t            cur_s1;
	logic [PIX_W-1:0]  up_rd;
	pixel_t            up_s1;
	code_t             code_s1;

	pixel_t            left_q;
	pixel_t            upper_left_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_next;
	logic [ADDR_W-1:0] col_m1;
	logic              residue_hit;

	logic                 out_valid_q;
	logic [COL_OUT_W-1:0] out_column_q;
	logic [ROW_W-1:0]     out_row_q;
	code_t                out_code_q;
	logic [CNT_W-1:0]     out_count_q;
	logic                 out_last_q;

	// Handshake: take a new request whenever the compare stage can drain
	assign out_free       = !out_valid_q || residue_out.ready;
	assign s1_adv         = valid_s1 && out_free;
	assign pixel_in.ready = !valid_s1 || out_free;
	assign in_fire        = pixel_in.valid && pixel_in.ready;

	assign cur_in.avoid = pixel_in.avoid;
	assign cur_in.phase = PHASE_BITS'(pixel_in.phase);

	// Raster position and registers
	prd_raster u_raster (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (in_fire),
		.pos       (pos)
	);

	// Previous row: read at accept, write back as the pixel leaves stage one
	prd_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (s1_adv),
		.waddr (pos_s1.column),
		.wdata (cur_s1),
		.re    (in_fire),
		.raddr (pos.column),
		.rdata (up_rd)
	);

	assign up_s1 = up_rd;

	// Stage one: hold the pixel while its upper neighbour is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pos_s1 <= pos;
			cur_s1 <= cur_in;
		end
	end

	// Loop sum and residue code
	prd_classify u_classify (
		.upper_left (upper_left_q),
		.up         (up_s1),
		.cur        (cur_s1),
		.left       (left_q),
		.code       (code_s1)
	);

	// Saturating residue count including this window
	assign residue_hit = pos_s1.window && ((code_s1 == CODE_POS) || (code_s1 == CODE_NEG));
	assign count_next  = (residue_hit && (count_q != '1)) ? count_q + CNT_W'(1) : count_q;
	assign col_m1      = pos_s1.column - ADDR_W'(1);

	// Shift the window neighbours and the frame count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			upper_left_q <= '0;
			count_q      <= '0;
		end else if (s1_adv) begin
			left_q       <= cur_s1;
			upper_left_q <= up_s1;
			count_q      <= pos_s1.last ? '0 : count_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= pos_s1.window;
		end else if (residue_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && pos_s1.window) begin
			out_column_q <= COL_OUT_W'(col_m1);
			out_row_q    <= pos_s1.row - ROW_W'(1);
			out_code_q   <= code_s1;
			out_count_q  <= count_next;
			out_last_q   <= pos_s1.last;
		end
	end

	assign residue_out.valid         = out_valid_q;
	assign residue_out.column        = out_column_q;
	assign residue_out.row           = out_row_q;
	assign residue_out.code          = out_code_q;
	assign residue_out.residue_count = out_count_q;
	assign residue_out.last          = out_last_q;

endmodule

/* rtl/prd_checker.sv */
// ----------------------------------------------------------------------------
// prd_checker: port-level checks for the phase residue detector
// Watches the pixel and residue channels and checks that each result has a pixel
// outstanding, the residue count sequence and the output hold under back-pressure.
// ----------------------------------------------------------------------------
module prd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [prd_pkg::COL_OUT_W-1:0] out_column,
	input logic [prd_pkg::ROW_W-1:0]     out_row,
	input prd_pkg::code_t                out_code,
	input logic [prd_pkg::CNT_W-1:0]     out_count,
	input logic                          out_last
);
	import prd_pkg::*;

	logic             in_fire;
	logic             out_fire;
	logic [31:0]      pending_q;
	logic [CNT_W-1:0] prev_count_q;
	logic [CNT_W-1:0] count_exp;
	logic             is_residue;

	assign in_fire    = in_valid && in_ready;
	assign out_fire   = out_valid && out_ready;
	assign is_residue = (out_code == CODE_POS) || (out_code == CODE_NEG);
	assign count_exp  = (is_residue && (prev_count_q != '1)) ?
	                    prev_count_q + CNT_W'(1) : prev_count_q;

	// Track requests taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_fire && !out_fire && (pending_q != '1)) begin
			pending_q <= pending_q + 32'd1;
		end else if (!in_fire && out_fire && (pending_q != '0)) begin
			pending_q <= pending_q - 32'd1;
		end
	end

	// Track the last delivered count of the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_count_q <= '0;
		end else if (out_fire) begin
			prev_count_q <= out_last ? '0 : out_count;
		end
	end

	a_no_result_without_pixel: assert property (
		@(posedge clk) disable iff (!arst_n)
		out_fire |-> (pending_q != '0)
	) else $error("residue result delivered with no pixel outstanding");

	a_count_sequence: assert property (
		@(posedge clk) disable iff (!arst_n)
		out_fire |-> (out_count == count_exp)
	) else $error("residue count does not follow the delivered codes");

	a_hold_on_stall: assert property (
		@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid &&
			$stable({out_column, out_row, out_code, out_count, out_last}))
	) else $error("stalled residue result changed");

endmodule

bind phase_residue_detector_top prd_checker u_prd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (pixel_in.valid),
	.in_ready   (pixel_in.ready),
	.out_valid  (residue_out.valid),
	.out_ready  (residue_out.ready),
	.out_column (residue_out.column),
	.out_row    (residue_out.row),
	.out_code   (residue_out.code),
	.out_count  (residue_out.residue_count),
	.out_last   (residue_out.last)
);

/* verif/residue_checker.sv */
// ----------------------------------------------------------------------------
// residue_checker: window predictor and scoreboard for the residue detector
// Watches the register port and both channels. Every accepted pixel is run
// through a local copy of the raster state and the line store; any window it
// completes is queued, and each accepted result is compared field by field
// with the oldest queued window.
// ----------------------------------------------------------------------------
module residue_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  prd_pkg::reg_index_t       cfg_index,
	input  logic [prd_pkg::CFG_W-1:0] cfg_data,
	prd_pixel_if                      pixel,
	prd_residue_if                    residue,
	output int                        failures,
	output int                        pending
);
	import prd_pkg::*;

	localparam longint FULL_CYCLE = longint'(1) << PHASE_BITS;
	localparam longint HALF_CYCLE = FULL_CYCLE / 2;
	localparam int     COUNT_MAX  = (1 << CNT_W) - 1;

	typedef struct packed {
		logic [COL_OUT_W-1:0] column;
		logic [ROW_W-1:0]     row;
		code_t                code;
		logic [CNT_W-1:0]     residue_count;
		logic                 last;
	} window_t;

	// Register copies and raster state
	logic [LW_W-1:0] width_reg;
	logic [FH_W-1:0] height_reg;
	pixel_t          row_above [MAX_WIDTH];
	pixel_t          left_px;
	pixel_t          upper_left_px;
	int unsigned     col_pos;
	int unsigned     row_pos;
	int unsigned     residues;

	window_t         windows_due [$];
	int              mismatches;
	int unsigned     windows_seen;

	// Wrap a phase step into the closed range around zero
	function automatic longint wrapped_step(pixel_t to_px, pixel_t from_px);
		longint d;
		d = longint'(to_px.phase) - longint'(from_px.phase);
		if (d > HALF_CYCLE)
			d -= FULL_CYCLE;
		else if (d < -HALF_CYCLE)
			d += FULL_CYCLE;
		return d;
	endfunction

	// Classify a window from its four corners, going round clockwise
	function automatic code_t loop_code(pixel_t ul, pixel_t ur, pixel_t lr, pixel_t ll);
		longint sum;
		if (ul.avoid || ur.avoid || lr.avoid || ll.avoid)
			return CODE_SKIP;
		sum = wrapped_step(ur, ul) + wrapped_step(lr, ur)
		    + wrapped_step(ll, lr) + wrapped_step(ul, ll);
		if (sum > 0)
			return CODE_POS;
		if (sum < 0)
			return CODE_NEG;
		return CODE_NONE;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("window %0d: %s expected %0d, got %0d",
				         windows_seen, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		window_t     want;
		window_t     got;
		pixel_t      cur;
		pixel_t      up;
		int unsigned w;
		int unsigned h;
		if (!arst_n) begin
			width_reg     = LINE_WIDTH_RESET;
			height_reg    = FRAME_HEIGHT_RESET;
			left_px       = '0;
			upper_left_px = '0;
			col_pos       = 0;
			row_pos       = 0;
			residues      = 0;
			for (int i = 0; i < MAX_WIDTH; i++)
				row_above[i] = '0;
			windows_due.delete();
			pending <= 0;
		end else begin
			// Track register writes
			if (cfg_we) begin
				if (cfg_index == REG_LINE_WIDTH)
					width_reg = cfg_data[LW_W-1:0];
				else
					height_reg = cfg_data[FH_W-1:0];
			end

			// Compare a delivered window with the oldest prediction
			if (residue.valid && residue.ready) begin
				got.column        = residue.column;
				got.row           = residue.row;
				got.code          = residue.code;
				got.residue_count = residue.residue_count;
				got.last          = residue.last;
				if (windows_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("window %0d: unexpected, column %0d row %0d code %0d",
						         windows_seen, got.column, got.row, got.code);
				end else begin
					want = windows_due.pop_front();
					check_field("column", want.column, got.column);
					check_field("row", want.row, got.row);
					check_field("code", want.code, got.code);
					check_field("residue_count", want.residue_count, got.residue_count);
					check_field("last", want.last, got.last);
				end
				windows_seen++;
			end

			// Advance the raster on each accepted pixel request
			if (pixel.valid && pixel.ready) begin
				w = width_reg;
				if (w < 2)
					w = 2;
				if (w > MAX_WIDTH)
					w = MAX_WIDTH;
				h = height_reg;
				if (h < 2)
					h = 2;
				cur.avoid = pixel.avoid;
				cur.phase = pixel.phase[PHASE_BITS-1:0];
				up = (col_pos < MAX_WIDTH) ? row_above[col_pos] : '0;

				if (row_pos >= 1 && col_pos >= 1) begin
					want.code = loop_code(upper_left_px, up, cur, left_px);
					if ((want.code == CODE_POS || want.code == CODE_NEG)
					    && residues < COUNT_MAX)
						residues++;
					want.column        = COL_OUT_W'(col_pos - 1);
					want.row           = ROW_W'(row_pos - 1);
					want.residue_count = CNT_W'(residues);
					want.last          = (col_pos + 1 >= w) && (row_pos + 1 >= h);
					windows_due.push_back(want);
				end

				upper_left_px = up;
				left_px       = cur;
				if (col_pos < MAX_WIDTH)
					row_above[col_pos] = cur;

				// Wrap column, row and count at the limits in force now
				col_pos++;
				if (col_pos >= w) begin
					col_pos = 0;
					row_pos++;
					if (row_pos >= h) begin
						row_pos  = 0;
						residues = 0;
					end
				end
			end
			pending <= windows_due.size();
		end
	end

	always @(posedge clk)
		failures <= mismatches;

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: top level for the phase residue detector
// Drives pixel frames of many sizes through the block with random idling on
// both channels, rewrites the frame geometry between and within frames, and leaves the
// prediction and comparison to residue_checker.
// ----------------------------------------------------------------------------
module testbench;
	import prd_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int TIMEOUT_CYCLES = 2_000_000;
	localparam int TOTAL_ITEMS    = 1850;
	localparam int SETTLE_CYCLES  = 4;
	localparam int DRAIN_CYCLES   = 8;
	localparam int LONG_HOLD      = 300;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	reg_index_t       cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int               failures;
	int               pending;

	bit               src_gaps;
	bit               snk_gaps;
	int unsigned      hold_requests;
	int unsigned      eff_width;
	int unsigned      eff_height;
	int unsigned      items_sent;

	prd_pixel_if   px ();
	prd_residue_if rs ();

	phase_residue_detector_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pixel_in    (px),
		.residue_out (rs)
	);

	residue_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (px),
		.residue   (rs),
		.failures  (failures),
		.pending   (pending)
	);

	always begin
		clk = 1'b0;
		#(CLK_PERIOD / 2);
		clk = 1'b1;
		#(CLK_PERIOD / 2);
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned idle_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one pixel request and hold it until taken
	task automatic send_pixel(input logic [PHASE_IN_W-1:0] ph, input logic av);
		int unsigned gap;
		gap = src_gaps ? idle_gap() : 0;
		if (gap > 0) begin
			px.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		px.valid <= 1'b1;
		px.phase <= ph;
		px.avoid <= av;
		@(posedge clk);
		while (!px.ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Stop offering, let every predicted window arrive and the pipe empty
	task automatic settle();
		px.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input logic [CFG_W-1:0] width_word,
	                          input logic [CFG_W-1:0] height_word);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_LINE_WIDTH;
		cfg_data  <= width_word;
		@(posedge clk);
		cfg_index <= REG_FRAME_HEIGHT;
		cfg_data  <= height_word;
		@(posedge clk);
		cfg_we    <= 1'b0;
		// Frame size as the block will apply it
		eff_width  = width_word[LW_W-1:0];
		if (eff_width < 2)
			eff_width = 2;
		if (eff_width > MAX_WIDTH)
			eff_width = MAX_WIDTH;
		eff_height = height_word[FH_W-1:0];
		if (eff_height < 2)
			eff_height = 2;
	endtask

	// A run of pixels: noise, or a smooth field with occasional jumps
	task automatic send_run(input int unsigned count, input bit noisy,
	                        input int unsigned avoid_pct);
		int unsigned level;
		int unsigned n;
		level = $urandom;
		for (n = 0; n < count; n++) begin
			if (noisy || $urandom_range(99) < 8)
				level = $urandom;
			else
				level = level + $urandom_range(6000) - 3000;
			send_pixel(PHASE_IN_W'(level), $urandom_range(99) < avoid_pct);
		end
	endtask

	// One whole frame at the current geometry
	task automatic send_frame(input bit noisy, input int unsigned avoid_pct);
		send_run(eff_width * eff_height, noisy, avoid_pct);
	endtask

	// Receiver: random stalls, plus a long hold-off whenever one is requested
	initial begin
		int unsigned held;
		int unsigned holds_done;
		held       = 0;
		holds_done = 0;
		rs.ready   = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				holds_done++;
				held = LONG_HOLD;
			end else if (held == 0 && snk_gaps && $urandom_range(99) < 25) begin
				held = idle_gap();
			end
			if (held > 0) begin
				rs.ready <= 1'b0;
				held--;
			end else begin
				rs.ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned            frames;
		int unsigned            roll;
		int unsigned            w_lo;
		int unsigned            h_word;
		int unsigned            avoid_pct;
		logic [1:0]             mode;
		logic [CFG_W-LW_W-1:0]  upper;

		cfg_we        = 1'b0;
		cfg_index     = REG_LINE_WIDTH;
		cfg_data      = '0;
		px.valid      = 1'b0;
		px.phase      = '0;
		px.avoid      = 1'b0;
		src_gaps      = 1'b0;
		snk_gaps      = 1'b0;
		hold_requests = 0;
		eff_width     = 1024;
		eff_height    = 1024;
		items_sent    = 0;
		frames        = 0;
		arst_n        = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Smallest frame: one positive loop, then one negative loop
		write_regs(16'd2, 16'd2);
		send_pixel(16'd0, 1'b0);     send_pixel(16'd16384, 1'b0);
		send_pixel(16'd49152, 1'b0); send_pixel(16'd32768, 1'b0);
		send_pixel(16'd0, 1'b0);     send_pixel(16'd49152, 1'b0);
		send_pixel(16'd16384, 1'b0); send_pixel(16'd32768, 1'b0);

		// Half-cycle steps, phase extremes and a masked corner
		write_regs(16'd3, 16'd3);
		src_gaps = 1'b1;
		snk_gaps <= 1'b1;
		send_pixel(16'd0, 1'b0);     send_pixel(16'd32768, 1'b0);
		send_pixel(16'd65535, 1'b0);
		send_pixel(16'd32768, 1'b0); send_pixel(16'd0, 1'b0);
		send_pixel(16'd32768, 1'b0);
		send_pixel(16'd65535, 1'b0); send_pixel(16'd16384, 1'b0);
		send_pixel(16'd0, 1'b1);

		// Shrink both limits mid-frame, below range too: next pixel ends it
		send_pixel(16'd1000, 1'b0);  send_pixel(16'd20000, 1'b0);
		send_pixel(16'd40000, 1'b0);
		send_pixel(16'd60000, 1'b0); send_pixel(16'd5000, 1'b0);
		write_regs(16'hF800, 16'd1);
		send_pixel(16'd30000, 1'b0);

		// Width above range: one full-width row, then a short second row
		write_regs(16'hFFFF, 16'd2);
		send_run(MAX_WIDTH, 1'b0, 5);
		write_regs(16'd6, 16'd2);
		send_run(6, 1'b0, 5);

		// Tallest limit, streamed without idling, then cut short mid-frame
		write_regs(16'd2, 16'hFFFF);
		src_gaps = 1'b0;
		snk_gaps <= 1'b0;
		send_run(20, 1'b0, 2);
		write_regs(16'd2, 16'd2);
		send_run(2, 1'b0, 2);

		// Long receiver hold-off while pixels keep coming
		write_regs(16'd8, 16'd8);
		hold_requests <= hold_requests + 1;
		send_frame(1'b1, 0);

		// Random frames, geometry changed between most of them
		while (items_sent < TOTAL_ITEMS) begin
			if (frames == 0 || $urandom_range(2) != 0) begin
				roll = $urandom_range(99);
				if (roll < 8)
					w_lo = $urandom_range(1);
				else if (roll < 25)
					w_lo = $urandom_range(11, 48);
				else
					w_lo = $urandom_range(2, 10);
				roll = $urandom_range(99);
				if (roll < 10)
					h_word = $urandom_range(1);
				else if (roll < 80 || w_lo > 10)
					h_word = $urandom_range(2, 6);
				else
					h_word = $urandom_range(7, 24);
				upper = ($urandom_range(9) < 3) ? (CFG_W-LW_W)'($urandom) : '0;
				write_regs({upper, LW_W'(w_lo)}, CFG_W'(h_word));
			end
			mode = 2'($urandom);
			src_gaps = mode[0];
			snk_gaps <= mode[1];
			if (frames % 25 == 7)
				hold_requests <= hold_requests + 1;
			if ($urandom_range(3) == 3)
				avoid_pct = 25;
			else
				avoid_pct = $urandom_range(1) ? 6 : 0;
			send_frame($urandom_range(1), avoid_pct);
			frames++;
		end

		// Drain and give the verdict
		px.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("FAIL");
		$finish;
	end

endmodule
